FILE: hw/rtl/pclp_pkg.sv
`default_nettype none

package pclp_pkg;

  localparam logic [1:0] CfgPropGain    = 2'd0;
  localparam logic [1:0] CfgIntGain     = 2'd1;
  localparam logic [1:0] CfgWindupLimit = 2'd2;
  localparam logic [1:0] CfgPwmPeriod   = 2'd3;

  localparam logic [17:0] FullScale = 18'd200000;
  // ceil(2^18 / 5): exact quotient by 5 for magnitudes below 2^18
  localparam logic [15:0] Recip5    = 16'd52429;
  // ceil(2^40 / 3125): exact quotient by 3125 for magnitudes below 2^29,
  // applied to the period product shifted down by 6 (200000 = 64 * 3125)
  localparam logic [28:0] RecipFs   = 29'd351843721;

  localparam logic [4:0] LimDivSteps  = 5'd31;

  typedef struct packed {
    logic        start;
    logic [17:0] rem_init;
    logic [34:0] dividend;
    logic [17:0] divisor;
    logic [4:0]  count;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pclp_div.sv
`default_nettype none

module pclp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pclp_pkg::div_req_t req_i,
  output pclp_pkg::div_rsp_t rsp_o
);
  import pclp_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [17:0] rem_q;
  logic [17:0] divisor_q;
  logic [34:0] sh_q;
  logic [30:0] quo_q;

  logic [18:0] trial;
  logic [18:0] diff;
  logic        fit;

  assign trial = {rem_q, sh_q[34]};
  assign fit   = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.rem_init;
      sh_q      <= req_i.dividend;
      divisor_q <= req_i.divisor;
      quo_q     <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? diff[17:0] : trial[17:0];
      sh_q  <= {sh_q[33:0], 1'b0};
      quo_q <= {quo_q[29:0], fit};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pi_current_loop_pwm.sv
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   ref_current_i, meas_current_i
// out      output     out_valid_o / out_ready_i duty_count_o, reverse_dir_o
// cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
// From accept to result, six steps form the error, integrator and drive, and four
// scale the duty (period product, reciprocal product in two halves).
// Full-scale drive skips the scaling; the windup clamp adds the 31-step limit / gain
// divide and a second gain product. in_ready_o rises together with the result load;
// the next word may run while out_ready_i stalls. Reset loads the register defaults
// and clears the integrator.
`default_nettype none

module pi_current_loop_pwm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] ref_current_i,
  input  logic signed [15:0] meas_current_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        duty_count_o,
  output logic               reverse_dir_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  import pclp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL5, S_SAT, S_MULI, S_CMP, S_DIVI, S_MULP,
    S_SUMU, S_MULD, S_MULL, S_MULH, S_SCALE, S_DONE
  } state_e;

  state_e state_q;

  logic [15:0] prop_gain_q;
  logic [15:0] int_gain_q;
  logic [30:0] windup_limit_q;
  logic [16:0] pwm_period_q;

  logic signed [16:0] e_q;
  logic signed [31:0] integ_q;
  logic signed [51:0] prod_q;
  logic signed [48:0] kterm_q;
  logic [17:0]        umag_q;
  logic [43:0]        rlo_q;
  logic               clamp_neg_q;
  logic               dir_q;
  logic [16:0]        duty_w_q;
  logic               out_valid_q;
  logic [16:0]        duty_q;
  logic               rdir_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] mul_p;
  logic [16:0]        e_mag;
  logic [13:0]        q5;
  logic signed [33:0] q5s;
  logic signed [33:0] sum34;
  logic signed [31:0] integ_sat;
  logic signed [51:0] lim52;
  logic               pos_over;
  logic               neg_over;
  logic signed [49:0] u;
  logic [49:0]        umag;
  logic [57:0]        scaled;

  assign e_mag = e_q[16] ? 17'(-e_q) : e_q;

  always_comb begin
    unique case (state_q)
      S_MUL5: begin
        mul_a = {16'b0, e_mag};
        mul_b = {3'b0, Recip5};
      end
      S_MULI: begin
        mul_a = {integ_q[31], integ_q};
        mul_b = {3'b0, int_gain_q};
      end
      S_MULP: begin
        mul_a = {{16{e_q[16]}}, e_q};
        mul_b = {3'b0, prop_gain_q};
      end
      S_MULD: begin
        mul_a = {15'b0, umag_q};
        mul_b = {2'b0, pwm_period_q};
      end
      S_MULL: begin
        mul_a = {4'b0, prod_q[34:6]};
        mul_b = {4'b0, RecipFs[14:0]};
      end
      S_MULH: begin
        mul_a = {4'b0, prod_q[34:6]};
        mul_b = {5'b0, RecipFs[28:15]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign q5    = prod_q[31:18];
  assign q5s   = e_q[16] ? -$signed({20'b0, q5}) : $signed({20'b0, q5});
  assign sum34 = $signed({{2{integ_q[31]}}, integ_q}) + q5s;

  always_comb begin
    if (sum34[33:31] == 3'b000 || sum34[33:31] == 3'b111) begin
      integ_sat = sum34[31:0];
    end else if (sum34[33]) begin
      integ_sat = 32'sh8000_0000;
    end else begin
      integ_sat = 32'sh7FFF_FFFF;
    end
  end

  assign lim52    = $signed({21'b0, windup_limit_q});
  assign pos_over = prod_q > lim52;
  assign neg_over = prod_q < -lim52;

  assign u    = $signed({{16{prod_q[33]}}, prod_q[33:0]}) + $signed({kterm_q[48], kterm_q});
  assign umag = u[49] ? 50'(-u) : 50'(u);

  assign scaled = {prod_q[42:0], 15'b0} + {14'b0, rlo_q};

  always_comb begin
    div_req.start    = state_q == S_CMP && (pos_over || neg_over);
    div_req.rem_init = '0;
    div_req.dividend = {windup_limit_q, 4'b0};
    div_req.divisor  = {2'b0, int_gain_q};
    div_req.count    = LimDivSteps;
  end

  pclp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= 16'd830;
      int_gain_q     <= 16'd230;
      windup_limit_q <= 31'd200000;
      pwm_period_q   <= 17'd4000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPropGain:    prop_gain_q    <= cfg_data_i[15:0];
        CfgIntGain:     int_gain_q     <= cfg_data_i[15:0];
        CfgWindupLimit: windup_limit_q <= cfg_data_i;
        CfgPwmPeriod:   pwm_period_q   <= cfg_data_i[16:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      e_q         <= '0;
      integ_q     <= '0;
      prod_q      <= '0;
      kterm_q     <= '0;
      umag_q      <= '0;
      rlo_q       <= '0;
      clamp_neg_q <= 1'b0;
      dir_q       <= 1'b0;
      duty_w_q    <= '0;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
      rdir_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            e_q     <= {ref_current_i[15], ref_current_i} - {meas_current_i[15], meas_current_i};
            state_q <= S_MUL5;
          end
        end
        S_MUL5: begin
          prod_q  <= mul_p;
          state_q <= S_SAT;
        end
        S_SAT: begin
          integ_q <= integ_sat;
          state_q <= S_MULI;
        end
        S_MULI: begin
          prod_q  <= mul_p;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (pos_over || neg_over) begin
            clamp_neg_q <= neg_over;
            state_q     <= S_DIVI;
          end else begin
            kterm_q <= prod_q[48:0];
            state_q <= S_MULP;
          end
        end
        S_DIVI: begin
          if (div_rsp.done) begin
            integ_q <= clamp_neg_q ? -$signed({1'b0, div_rsp.quotient})
                                   : $signed({1'b0, div_rsp.quotient});
            state_q <= S_MULI;
          end
        end
        S_MULP: begin
          prod_q  <= mul_p;
          state_q <= S_SUMU;
        end
        S_SUMU: begin
          dir_q <= u[49];
          if (umag >= {32'b0, FullScale}) begin
            duty_w_q <= pwm_period_q;
            state_q  <= S_DONE;
          end else begin
            umag_q  <= umag[17:0];
            state_q <= S_MULD;
          end
        end
        S_MULD: begin
          prod_q  <= mul_p;
          state_q <= S_MULL;
        end
        S_MULL: begin
          rlo_q   <= mul_p[43:0];
          state_q <= S_MULH;
        end
        S_MULH: begin
          prod_q  <= mul_p;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          duty_w_q <= scaled[56:40];
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            duty_q      <= duty_w_q;
            rdir_q      <= dir_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign duty_count_o  = duty_q;
  assign reverse_dir_o = rdir_q;

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_count_o <= pwm_period_q)
    else $error("duty above period");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while busy");

  a_clamp_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVI) |-> int_gain_q != 16'd0)
    else $error("windup clamp with zero gain");
`endif

endmodule

`default_nettype wire

FILE: dv/pi_current_loop_pwm_tb.sv
`default_nettype none

module pi_current_loop_pwm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pclp_pkg::*;

  localparam int NumRows = 35;
  localparam int NumPhases = 10;
  localparam int PhaseWords = 193;
  localparam int QuietLimit = 4000;
  localparam int TailCycles = 70;
  localparam longint FullDrive = 200000;
  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [30:0] data;
    logic [15:0] ref_v;
    logic [15:0] meas_v;
    logic        typed;
    logic [16:0] duty;
    logic        dir;
  } row_t;

  typedef struct packed {
    logic [16:0] duty;
    logic        dir;
  } drive_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [15:0] ref_current_i;
  logic signed [15:0] meas_current_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [16:0]        duty_count_o;
  logic               reverse_dir_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [30:0]        cfg_data_i;

  logic [15:0] kp_r;
  logic [15:0] ki_r;
  logic [30:0] lim_r;
  logic [16:0] period_r;
  int          integ_r;

  drive_t drive_q[$];
  drive_t due_word;
  bit     idling;
  int     stall_left;
  int     words_sent;
  int     words_checked;
  int     mismatches;
  int     settings_applied;

  pi_current_loop_pwm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ref_current_i (ref_current_i),
    .meas_current_i(meas_current_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_count_o  (duty_count_o),
    .reverse_dir_o (reverse_dir_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void predict_drive(input logic signed [15:0] r, m,
                                        output logic [16:0] duty, output logic dir);
    longint err, acc, ki, lim, u, mag;
    err = longint'(r) - longint'(m);
    ki  = longint'(ki_r);
    lim = longint'(lim_r);
    acc = longint'(integ_r) + err / 5;
    if (acc > IntegMax) begin
      acc = IntegMax;
    end else if (acc < IntegMin) begin
      acc = IntegMin;
    end
    if (ki != 0) begin
      if (ki * acc > lim) begin
        acc = lim / ki;
      end else if (ki * acc < -lim) begin
        acc = -(lim / ki);
      end
    end
    integ_r = int'(acc);
    u = longint'(kp_r) * err + ki * acc;
    mag = (u < 0) ? -u : u;
    if (mag >= FullDrive) begin
      duty = period_r;
    end else begin
      duty = 17'((mag * longint'(period_r)) / FullDrive);
    end
    dir = (u < 0);
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // spread over magnitudes, all ones now and then
  function automatic logic [31:0] wide_rand(int unsigned bits);
    if ($urandom_range(0, 7) == 0) return (32'h1 << bits) - 1;
    return $urandom() >> $urandom_range(32 - bits, 31);
  endfunction

  function automatic row_t word_row(logic signed [15:0] r, m);
    return '{RowWord, CfgPropGain, 31'd0, r, m, 1'b0, 17'd0, 1'b0};
  endfunction

  function automatic row_t typed_row(logic signed [15:0] r, m, logic [16:0] duty,
                                     logic dir);
    return '{RowWord, CfgPropGain, 31'd0, r, m, 1'b1, duty, dir};
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [30:0] data);
    return '{RowCfg, idx, data, 16'd0, 16'd0, 1'b0, 17'd0, 1'b0};
  endfunction

  task automatic push_word(input logic signed [15:0] r, m, input logic typed,
                           input logic [16:0] typed_duty, input logic typed_dir);
    drive_t due;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    ref_current_i  <= r;
    meas_current_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    predict_drive(r, m, due.duty, due.dir);
    if (typed) begin
      due.duty = typed_duty;
      due.dir  = typed_dir;
    end
    drive_q.push_back(due);
    words_sent++;
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [30:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgPropGain:    kp_r = data[15:0];
      CfgIntGain:     ki_r = data[15:0];
      CfgWindupLimit: lim_r = data;
      CfgPwmPeriod:   period_r = data[16:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] kp, ki, input logic [30:0] lim,
                               input logic [16:0] per);
    settle();
    cfg_write(CfgPropGain, 31'(kp));
    cfg_write(CfgIntGain, 31'(ki));
    cfg_write(CfgWindupLimit, lim);
    cfg_write(CfgPwmPeriod, 31'(per));
    settings_applied++;
  endtask

  initial begin : stimulus
    row_t               rows [NumRows];
    int                 ph;
    int                 n;
    int                 pick;
    int                 span;
    int                 set_pt;
    int                 plant;
    logic signed [15:0] r;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    ref_current_i  = '0;
    meas_current_i = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgPropGain;
    cfg_data_i     = '0;
    kp_r           = 16'd830;
    ki_r           = 16'd230;
    lim_r          = 31'd200000;
    period_r       = 17'd4000;
    integ_r        = 0;
    idling         = 1'b1;
    words_sent     = 0;
    words_checked  = 0;
    mismatches     = 0;
    settings_applied = 1;
    set_pt         = 0;
    plant          = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      typed_row(0, 0, 17'd0, 1'b0),
      typed_row(32767, -32768, 17'd4000, 1'b0),
      typed_row(-32768, 32767, 17'd4000, 1'b1),
      word_row(100, 0),
      word_row(-100, 50),
      word_row(7, 3),
      word_row(-3, 1),
      word_row(-32768, -32768),
      cfg_row(CfgPwmPeriod, 31'd0),
      typed_row(32767, -32768, 17'd0, 1'b0),
      cfg_row(CfgPwmPeriod, 31'd131071),
      typed_row(32767, -32768, 17'd131071, 1'b0),
      cfg_row(CfgPwmPeriod, 31'd65536),
      word_row(1, 0),
      word_row(0, 1),
      cfg_row(CfgIntGain, 31'd0),
      word_row(32767, -32768),
      word_row(-32768, 32767),
      word_row(-32768, 32767),
      cfg_row(CfgPropGain, 31'd65535),
      cfg_row(CfgIntGain, 31'd65535),
      cfg_row(CfgWindupLimit, 31'd0),
      typed_row(32767, -32768, 17'd65536, 1'b0),
      typed_row(-32768, 32767, 17'd65536, 1'b1),
      word_row(0, 0),
      cfg_row(CfgWindupLimit, 31'h7FFF_FFFF),
      word_row(32767, -32768),
      word_row(0, 0),
      cfg_row(CfgPropGain, 31'd0),
      word_row(0, 0),
      word_row(4, 0),
      word_row(-32768, 32767),
      cfg_row(CfgIntGain, 31'd1),
      word_row(32767, -32768),
      word_row(1, 0)
    };

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        settle();
        cfg_write(rows[i].idx, rows[i].data);
        settings_applied++;
      end else begin
        push_word(rows[i].ref_v, rows[i].meas_v, rows[i].typed, rows[i].duty,
                  rows[i].dir);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      idling = (ph % 3 != 2) && (ph != NumPhases - 1);
      if (ph == 0 || ph == NumPhases - 1) begin
        apply_setting(16'd830, 16'd230, 31'd200000, 17'd4000);
      end else begin
        apply_setting(16'(wide_rand(16)), 16'(wide_rand(16)), 31'(wide_rand(31)),
                      17'(wide_rand(17)));
      end
      for (n = 0; n < PhaseWords; n++) begin
        if (n % 32 == 0) set_pt = int'($urandom_range(0, 65535)) - 32768;
        pick = $urandom_range(0, 7);
        if (pick < 3) begin
          // closed-loop run: measured current chases the setpoint
          plant = clip16(plant + (set_pt - plant) / 4 + int'($urandom_range(0, 40)) - 20);
          push_word(clip16(set_pt), clip16(plant), 1'b0, 17'd0, 1'b0);
        end else if (pick < 6) begin
          r = 16'($urandom());
          span = 1 << $urandom_range(0, 12);
          push_word(r, clip16(int'(r) + int'($urandom_range(0, 2 * span)) - span),
                    1'b0, 17'd0, 1'b0);
        end else begin
          push_word(16'($urandom()), 16'($urandom()), 1'b0, 17'd0, 1'b0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d words driven under %0d register settings (gains, limit, period extremes)",
             words_sent, settings_applied);
    $display("%0d results compared, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        $error("result with no word pending: duty_count %0d, reverse_dir %0b",
               duty_count_o, reverse_dir_o);
        mismatches++;
      end else begin
        due_word = drive_q.pop_front();
        words_checked++;
        if (duty_count_o !== due_word.duty) begin
          $error("duty_count: expected %0d, got %0d", due_word.duty, duty_count_o);
          mismatches++;
        end
        if (reverse_dir_o !== due_word.dir) begin
          $error("reverse_dir: expected %0b, got %0b", due_word.dir, reverse_dir_o);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no handshake for %0d cycles", QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: pi_current_loop_pwm.f
hw/rtl/pclp_pkg.sv
hw/rtl/pclp_div.sv
hw/rtl/pi_current_loop_pwm.sv
dv/pi_current_loop_pwm_tb.sv
